[src/rsid_pkg.sv]
// Shared types, codes and constants of the radio sender identifier table.
`default_nettype none

package rsid_pkg;

  // Default number of table slots
  localparam int DEFAULT_TABLE_DEPTH = 32;

  // Field widths
  localparam int OPERATION_W   = 2;
  localparam int TTYPE_W       = 8;
  localparam int SENDER_ID_W   = 32;
  localparam int DATA_BYTE_W   = 8;
  localparam int ENTRY_INDEX_W = 6;
  localparam int STATUS_W      = 2;
  localparam int FOUND_INDEX_W = 5;
  localparam int FUNC_W        = 6;
  localparam int KIND_W        = 7;
  localparam int ENTRY_COUNT_W = 6;

  // Width used to compare the delete slot against the fill count
  localparam int CMP_W = 7;

  // Known telegram type bytes
  localparam logic [TTYPE_W-1:0] TYPE_RPS = 8'hF6;
  localparam logic [TTYPE_W-1:0] TYPE_1BS = 8'hD5;
  localparam logic [TTYPE_W-1:0] TYPE_4BS = 8'hA5;

  // Low type bits taken from data byte 3
  localparam logic [DATA_BYTE_W-1:0] TYPE_LOW_MASK = 8'h03;

  typedef enum logic [OPERATION_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // One table entry
  typedef struct packed {
    logic [TTYPE_W-1:0]     ttype;
    logic [SENDER_ID_W-1:0] sid;
    logic [FUNC_W-1:0]      func;
    logic [KIND_W-1:0]      kind;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    latch;
    logic    add_wr;
    logic    clear;
    logic    dec;
    logic    scan_start;
    logic    scan_go;
    logic    res_load;
    status_t res_status;
    logic    res_hit;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic known;
    logic full;
    logic empty;
    logic idx_bad;
    logic hit;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

[src/rsid_ctrl.sv]
// Sequencing state machine of the radio sender identifier table.
`default_nettype none

module rsid_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire rsid_pkg::sts_t sts,
  output rsid_pkg::cmd_t     cmd
);
  import rsid_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_MOVE = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_ADD: begin
            cmd.res_load = 1'b1;
            state_next   = S_DONE;
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else if (!sts.known) begin
              cmd.res_status = ST_FAIL;
            end else begin
              cmd.add_wr = 1'b1;
            end
          end
          OP_SEARCH: begin
            if (sts.empty || !sts.known) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FAIL;
              state_next     = S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          OP_DELETE: begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_next     = S_DONE;
            end else if (sts.idx_bad) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FAIL;
              state_next     = S_DONE;
            end else begin
              // last entry is being read this cycle
              state_next = S_MOVE;
            end
          end
          default: begin
            cmd.clear    = 1'b1;
            cmd.res_load = 1'b1;
            state_next   = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_go = 1'b1;
        if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_hit  = 1'b1;
          state_next   = S_DONE;
        end else if (sts.last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_FAIL;
          state_next     = S_DONE;
        end
      end
      S_MOVE: begin
        cmd.dec      = 1'b1;
        cmd.res_load = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A finished result always passes through the hand-over state
  a_res_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> state == S_DONE)
    else $error("result loaded without reaching hand-over state");

  // Hand-over with a free output register raises valid
  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> out_valid && state == S_IDLE)
    else $error("result not presented after hand-over");

  // A scan never runs while an item is being taken in
  a_scan_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_go |-> !cmd.latch && !cmd.add_wr && !cmd.dec)
    else $error("scan overlaps another operation");

endmodule

`default_nettype wire

[src/rsid_datapath.sv]
// Entry memory, fill count, search scan and result registers of the sender table.
`default_nettype none

module rsid_datapath #(
  parameter int TABLE_DEPTH = rsid_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire rsid_pkg::cmd_t                        cmd,
  output rsid_pkg::sts_t                             sts,
  input  wire logic [rsid_pkg::OPERATION_W-1:0]      operation,
  input  wire logic [rsid_pkg::TTYPE_W-1:0]          telegram_type,
  input  wire logic [rsid_pkg::SENDER_ID_W-1:0]      sender_id,
  input  wire logic [rsid_pkg::DATA_BYTE_W-1:0]      data_three,
  input  wire logic [rsid_pkg::DATA_BYTE_W-1:0]      data_two,
  input  wire logic [rsid_pkg::ENTRY_INDEX_W-1:0]    entry_index,
  output logic [rsid_pkg::STATUS_W-1:0]              status,
  output logic [rsid_pkg::FOUND_INDEX_W-1:0]         found_index,
  output logic [rsid_pkg::TTYPE_W-1:0]               found_type,
  output logic [rsid_pkg::FUNC_W-1:0]                found_func,
  output logic [rsid_pkg::KIND_W-1:0]                found_kind,
  output logic [rsid_pkg::ENTRY_COUNT_W-1:0]         entry_count
);
  import rsid_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Latched item
  op_t                      op_q;
  logic [TTYPE_W-1:0]       type_q;
  logic [SENDER_ID_W-1:0]   sid_q;
  logic [DATA_BYTE_W-1:0]   d3_q;
  logic [DATA_BYTE_W-1:0]   d2_q;
  logic [ENTRY_INDEX_W-1:0] idx_q;

  // Table state
  entry_t                   mem [TABLE_DEPTH];
  entry_t                   rd_data;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            count_m1;
  logic [CW-1:0]            scan_addr;
  logic [CW-1:0]            rd_addr_q;
  logic [CW-1:0]            rd_sel;
  logic                     rd_pend;
  entry_t                   new_entry;
  logic                     match;

  // Pending result
  status_t                  pend_status;
  logic [FOUND_INDEX_W-1:0] pend_idx;
  logic [TTYPE_W-1:0]       pend_type;
  logic [FUNC_W-1:0]        pend_func;
  logic [KIND_W-1:0]        pend_kind;
  logic [ENTRY_COUNT_W-1:0] pend_count;

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= op_t'(operation);
      type_q <= telegram_type;
      sid_q  <= sender_id;
      d3_q   <= data_three;
      d2_q   <= data_two;
      idx_q  <= entry_index;
    end
  end

  // Entry to append; codes only for four-byte telegrams
  always_comb begin
    new_entry.ttype = type_q;
    new_entry.sid   = sid_q;
    new_entry.func  = '0;
    new_entry.kind  = '0;
    if (type_q == TYPE_4BS) begin
      new_entry.func = d3_q[DATA_BYTE_W-1:2];
      new_entry.kind = {d3_q[1:0] & TYPE_LOW_MASK[1:0], d2_q[DATA_BYTE_W-1:3]};
    end
  end

  assign count_m1 = count - CW'(1);
  assign rd_sel   = cmd.scan_go ? scan_addr : count_m1;
  assign match    = (rd_data.ttype == type_q) && (rd_data.sid == sid_q);

  // Status towards the controller
  always_comb begin
    sts.op      = op_q;
    sts.known   = (type_q == TYPE_RPS) || (type_q == TYPE_1BS) || (type_q == TYPE_4BS);
    sts.full    = (count == CW'(TABLE_DEPTH));
    sts.empty   = (count == '0);
    sts.idx_bad = ({1'b0, idx_q} >= CMP_W'(count));
    sts.hit     = rd_pend && match;
    sts.last    = rd_pend && (rd_addr_q == count_m1);
  end

  // Fill count
  always_comb begin
    count_next = count;
    if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.add_wr) begin
      count_next = count + CW'(1);
    end else if (cmd.dec) begin
      count_next = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Memory write port: append, or move last entry into freed slot
  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      mem[count[IW-1:0]] <= new_entry;
    end else if (cmd.dec) begin
      mem[idx_q[IW-1:0]] <= rd_data;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_sel[IW-1:0]];
  end

  // Scan address and compare-stage tag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_pend <= 1'b0;
    end else if (cmd.scan_go) begin
      rd_pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (cmd.scan_go) begin
      scan_addr <= scan_addr + CW'(1);
      rd_addr_q <= scan_addr;
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      pend_status <= cmd.res_status;
      pend_count  <= ENTRY_COUNT_W'(count_next);
      if (cmd.res_hit) begin
        pend_idx  <= FOUND_INDEX_W'(rd_addr_q);
        pend_type <= rd_data.ttype;
        pend_func <= rd_data.func;
        pend_kind <= rd_data.kind;
      end else begin
        pend_idx  <= '0;
        pend_type <= '0;
        pend_func <= '0;
        pend_kind <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= pend_status;
      found_index <= pend_idx;
      found_type  <= pend_type;
      found_func  <= pend_func;
      found_kind  <= pend_kind;
      entry_count <= pend_count;
    end
  end

  // Fill count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // Append grows the table by one
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.add_wr |=> count == CW'($past(count) + CW'(1)))
    else $error("append did not grow the fill count");

  // Slot moves happen only on a non-empty table with an index inside it
  a_move_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.dec |-> count != '0 && !sts.idx_bad)
    else $error("delete move on an invalid slot");

endmodule

`default_nettype wire

[src/radio_sender_id_table.sv]
// Add, clear and rejected operations go through the execute and hand-over states; a delete that
// moves an entry also goes through the move state. A search scans one slot per cycle through the
// single memory read port and ends on a hit or at the last filled slot.
// The next item is taken the cycle after a result enters the output register, so the table
// works on one item at a time, and any output stall holds off the next item.
// Reset (synchronous, active high) empties the table at once; entry contents stay undefined.
`default_nettype none

module radio_sender_id_table #(
  parameter int TABLE_DEPTH = rsid_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [rsid_pkg::OPERATION_W-1:0]   operation,
  input  wire logic [rsid_pkg::TTYPE_W-1:0]       telegram_type,
  input  wire logic [rsid_pkg::SENDER_ID_W-1:0]   sender_id,
  input  wire logic [rsid_pkg::DATA_BYTE_W-1:0]   data_three,
  input  wire logic [rsid_pkg::DATA_BYTE_W-1:0]   data_two,
  input  wire logic [rsid_pkg::ENTRY_INDEX_W-1:0] entry_index,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [rsid_pkg::STATUS_W-1:0]           status,
  output logic [rsid_pkg::FOUND_INDEX_W-1:0]      found_index,
  output logic [rsid_pkg::TTYPE_W-1:0]            found_type,
  output logic [rsid_pkg::FUNC_W-1:0]             found_func,
  output logic [rsid_pkg::KIND_W-1:0]             found_kind,
  output logic [rsid_pkg::ENTRY_COUNT_W-1:0]      entry_count
);
  import rsid_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller
  rsid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  rsid_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (operation),
    .telegram_type (telegram_type),
    .sender_id     (sender_id),
    .data_three    (data_three),
    .data_two      (data_two),
    .entry_index   (entry_index),
    .status        (status),
    .found_index   (found_index),
    .found_type    (found_type),
    .found_func    (found_func),
    .found_kind    (found_kind),
    .entry_count   (entry_count)
  );

endmodule

`default_nettype wire
